FILE: sv/psd_pkg.sv
// Shared constants for the point to segment distance block.
// No dependencies; used by point_segment_distance.
package psd_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int DIST_W = 33;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_END_X   = 2'd2;
    localparam logic [1:0] REG_END_Y   = 2'd3;

endpackage

FILE: sv/point_segment_distance.sv
// Point to line segment distance: APB segment registers, direction cache, stream pipeline.
// Depends on psd_pkg.
//
// One query point per cycle enters on the slave stream while o_s_tready is high, and its
// distance leaves on the master stream after passing through seven arithmetic stages,
// one stage per bit of the pipelined square root, and the output register. A stall on
// the master side freezes the whole pipeline. After reset and after every register
// write the segment length and unit direction are recomputed by an iterative unit, one
// root bit and then one quotient bit per cycle; s_tready stays low meanwhile.
// o_m_tuser carries the degenerate flag, set when the segment has zero length.
module point_segment_distance #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = psd_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [((COORD_BITS > 32) ? 5 : 4)-1:0] paddr,
    input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_BITS > 32) ? 64 : 32)-1:0] prdata,
    output logic pready,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // point_x, point_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // distance
    output logic [((psd_pkg::DIST_W+7)/8)*8-1:0] o_m_tdata,
    // degenerate
    output logic o_m_tuser
);

    localparam int CW   = COORD_BITS;
    localparam int PDW  = (CW > 32) ? 64 : 32;
    localparam int PAW  = (CW > 32) ? 5 : 4;
    localparam int ASH  = (CW > 32) ? 3 : 2;
    localparam int DW   = CW + 1;
    localparam int LW   = DW + 1;
    localparam int FW   = FRAC_BITS + 1;
    localparam int QDW  = FRAC_BITS + 2;
    localparam int SLO  = (DW + 1) / 2;
    localparam int SHI  = DW - SLO;
    localparam int RWS  = LW + 3;
    localparam int SCW  = $clog2(LW);
    localparam int DCW  = $clog2(FRAC_BITS + 1);
    localparam int PW   = DW + FW;
    localparam int SW   = PW + 1;
    localparam int RNW  = SW + 1 - FRAC_BITS;
    localparam int OPW  = LW + FW;
    localparam int OW   = OPW + 1 - FRAC_BITS;
    localparam int EW   = OW + 3;
    localparam int LO   = (EW + 1) / 2;
    localparam int HI   = EW - LO;
    localparam int NR   = EW + 1;
    localparam int RW   = NR + 3;
    localparam int PIPE = 8 + NR;
    localparam int DIST_W = psd_pkg::DIST_W;
    localparam int MXW  = (NR + 1 > DIST_W) ? NR + 1 : DIST_W;
    localparam int OUT_TW = ((DIST_W+7)/8)*8;

    typedef enum logic [2:0] {
        S_MUL, S_SUM, S_SQRT, S_ROUND, S_DINIT, S_DIV, S_FIN, S_DONE
    } t_cstate;

    // ---------------- configuration registers ----------------
    logic [CW-1:0] r_sx, r_sy, r_ex, r_ey;
    logic          cfg_wr;
    logic [1:0]    cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[PAW-1:ASH];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_ex <= '0;
            r_ey <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                psd_pkg::REG_START_X: r_sx <= pwdata[CW-1:0];
                psd_pkg::REG_START_Y: r_sy <= pwdata[CW-1:0];
                psd_pkg::REG_END_X:   r_ex <= pwdata[CW-1:0];
                psd_pkg::REG_END_Y:   r_ey <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            psd_pkg::REG_START_X: prdata = PDW'(r_sx);
            psd_pkg::REG_START_Y: prdata = PDW'(r_sy);
            psd_pkg::REG_END_X:   prdata = PDW'(r_ex);
            psd_pkg::REG_END_Y:   prdata = PDW'(r_ey);
            default:              prdata = '0;
        endcase
    end

    // ---------------- direction cache ----------------
    t_cstate             r_cst;
    logic                r_cache_valid;
    logic [SCW-1:0]      r_scnt;
    logic [DCW-1:0]      r_dcnt;
    logic [DW-1:0]       r_mx, r_my;
    logic                r_nx, r_ny;
    logic [2*SHI-1:0]    r_xhh, r_yhh;
    logic [DW-1:0]       r_xhl, r_yhl;
    logic [2*SLO-1:0]    r_xll, r_yll;
    logic [2*LW-1:0]     r_rad;
    logic [RWS-1:0]      r_rem;
    logic [LW-1:0]       r_root;
    logic [LW-1:0]       r_len;
    logic [LW-1:0]       r_dremx, r_dremy;
    logic [QDW-1:0]      r_qx, r_qy;
    logic [FW-1:0]       r_cmag, r_smag;
    logic                r_cneg, r_sneg;

    logic [DW-1:0]       c_dx, c_dy, c_mx, c_my;
    logic [2*LW-1:0]     c_sqx, c_sqy;
    logic [RWS-1:0]      c_rsh, c_trial;
    logic [LW:0]         c_tx, c_ty;
    logic [LW-1:0]       c_lenr;

    always_comb begin
        c_dx = {r_ex[CW-1], r_ex} - {r_sx[CW-1], r_sx};
        c_dy = {r_ey[CW-1], r_ey} - {r_sy[CW-1], r_sy};
        c_mx = c_dx[DW-1] ? (~c_dx + 1'b1) : c_dx;
        c_my = c_dy[DW-1] ? (~c_dy + 1'b1) : c_dy;
        c_sqx = ((2*LW)'(r_xhh) << (2*SLO)) + ((2*LW)'(r_xhl) << (SLO+1)) + (2*LW)'(r_xll);
        c_sqy = ((2*LW)'(r_yhh) << (2*SLO)) + ((2*LW)'(r_yhl) << (SLO+1)) + (2*LW)'(r_yll);
        c_rsh   = {r_rem[RWS-3:0], r_rad[2*LW-1 -: 2]};
        c_trial = RWS'({r_root, 2'b01});
        c_lenr  = (r_rem > RWS'(r_root)) ? r_root + 1'b1 : r_root;
        c_tx = {r_dremx, 1'b0};
        c_ty = {r_dremy, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cst         <= S_MUL;
            r_cache_valid <= 1'b0;
            r_scnt        <= '0;
            r_dcnt        <= '0;
            r_len         <= '0;
            r_cmag        <= '0;
            r_smag        <= '0;
            r_cneg        <= 1'b0;
            r_sneg        <= 1'b0;
        end else if (cfg_wr) begin
            r_cst         <= S_MUL;
            r_cache_valid <= 1'b0;
        end else begin
            case (r_cst)
                S_MUL: begin
                    r_mx  <= c_mx;
                    r_my  <= c_my;
                    r_nx  <= c_dx[DW-1];
                    r_ny  <= c_dy[DW-1];
                    r_xhh <= (2*SHI)'(c_mx[DW-1:SLO]) * (2*SHI)'(c_mx[DW-1:SLO]);
                    r_xhl <= DW'(c_mx[DW-1:SLO]) * DW'(c_mx[SLO-1:0]);
                    r_xll <= (2*SLO)'(c_mx[SLO-1:0]) * (2*SLO)'(c_mx[SLO-1:0]);
                    r_yhh <= (2*SHI)'(c_my[DW-1:SLO]) * (2*SHI)'(c_my[DW-1:SLO]);
                    r_yhl <= DW'(c_my[DW-1:SLO]) * DW'(c_my[SLO-1:0]);
                    r_yll <= (2*SLO)'(c_my[SLO-1:0]) * (2*SLO)'(c_my[SLO-1:0]);
                    r_cst <= S_SUM;
                end
                S_SUM: begin
                    r_rad  <= c_sqx + c_sqy;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_scnt <= SCW'(LW - 1);
                    r_cst  <= S_SQRT;
                end
                S_SQRT: begin
                    r_rad <= r_rad << 2;
                    if (c_rsh >= c_trial) begin
                        r_rem  <= c_rsh - c_trial;
                        r_root <= {r_root[LW-2:0], 1'b1};
                    end else begin
                        r_rem  <= c_rsh;
                        r_root <= {r_root[LW-2:0], 1'b0};
                    end
                    r_scnt <= r_scnt - 1'b1;
                    if (r_scnt == '0) begin
                        r_cst <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_len <= c_lenr;
                    r_cst <= S_DINIT;
                end
                S_DINIT: begin
                    if (LW'(r_mx) >= r_len) begin
                        r_qx    <= QDW'(1);
                        r_dremx <= LW'(r_mx) - r_len;
                    end else begin
                        r_qx    <= '0;
                        r_dremx <= LW'(r_mx);
                    end
                    if (LW'(r_my) >= r_len) begin
                        r_qy    <= QDW'(1);
                        r_dremy <= LW'(r_my) - r_len;
                    end else begin
                        r_qy    <= '0;
                        r_dremy <= LW'(r_my);
                    end
                    r_dcnt <= DCW'(FRAC_BITS - 1);
                    r_cst  <= S_DIV;
                end
                S_DIV: begin
                    if (c_tx >= {1'b0, r_len}) begin
                        r_dremx <= LW'(c_tx - {1'b0, r_len});
                        r_qx    <= {r_qx[QDW-2:0], 1'b1};
                    end else begin
                        r_dremx <= c_tx[LW-1:0];
                        r_qx    <= {r_qx[QDW-2:0], 1'b0};
                    end
                    if (c_ty >= {1'b0, r_len}) begin
                        r_dremy <= LW'(c_ty - {1'b0, r_len});
                        r_qy    <= {r_qy[QDW-2:0], 1'b1};
                    end else begin
                        r_dremy <= c_ty[LW-1:0];
                        r_qy    <= {r_qy[QDW-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == '0) begin
                        r_cst <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_len == '0) begin
                        r_cmag <= '0;
                        r_smag <= '0;
                        r_cneg <= 1'b0;
                        r_sneg <= 1'b0;
                    end else begin
                        r_cmag <= FW'((c_tx >= {1'b0, r_len}) ? r_qx + 1'b1 : r_qx);
                        r_smag <= FW'((c_ty >= {1'b0, r_len}) ? r_qy + 1'b1 : r_qy);
                        r_cneg <= r_nx;
                        r_sneg <= r_ny;
                    end
                    r_cache_valid <= 1'b1;
                    r_cst         <= S_DONE;
                end
                S_DONE: ;
                default: r_cst <= S_MUL;
            endcase
        end
    end

    // ---------------- item pipeline ----------------
    logic            en, acc;
    logic [PIPE-1:0] r_vld;

    assign en         = ~r_vld[PIPE-1] | i_m_tready;
    assign o_s_tready = en & r_cache_valid;
    assign acc        = i_s_tvalid & o_s_tready;
    assign o_m_tvalid = r_vld[PIPE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE-2:0], acc};
        end
    end

    logic [CW-1:0] px, py;
    logic [DW-1:0] s1_dx, s1_dy;
    assign px    = i_s_tdata[CW-1:0];
    assign py    = i_s_tdata[2*CW-1:CW];
    assign s1_dx = {px[CW-1], px} - {r_sx[CW-1], r_sx};
    assign s1_dy = {py[CW-1], py} - {r_sy[CW-1], r_sy};

    logic [CW-1:0]  r1_px, r1_py, r2_px, r2_py, r3_px, r3_py, r4_px, r4_py;
    logic [DW-1:0]  r1_mx, r1_my;
    logic           r1_nx, r1_ny;
    logic [PW-1:0]  r2_p1, r2_p2;
    logic           r2_n1, r2_n2;
    logic [LW-1:0]  r3_m;
    logic [OPW-1:0] r4_ox, r4_oy;
    logic [EW-1:0]  r5_ex, r5_ey;
    logic [2*HI-1:0] r6_xhh, r6_yhh;
    logic [EW-1:0]  r6_xhl, r6_yhl;
    logic [2*LO-1:0] r6_xll, r6_yll;

    logic [SW-1:0]  s3_sum;
    logic           s3_neg;
    logic [SW:0]    s3_rs;
    logic [RNW-1:0] s3_rnd;
    logic [LW-1:0]  s3_m;

    always_comb begin
        if (r2_n1 == r2_n2) begin
            s3_sum = SW'(r2_p1) + SW'(r2_p2);
            s3_neg = r2_n1;
        end else if (r2_p2 <= r2_p1) begin
            s3_sum = SW'(r2_p1 - r2_p2);
            s3_neg = r2_n1;
        end else begin
            s3_sum = SW'(r2_p2 - r2_p1);
            s3_neg = r2_n2;
        end
        s3_rs  = {1'b0, s3_sum} + (SW+1)'(1 << (FRAC_BITS - 1));
        s3_rnd = s3_rs[SW:FRAC_BITS];
        if (s3_neg || s3_rnd == '0 || r_len == '0) begin
            s3_m = LW'(1);
        end else if (s3_rnd >= RNW'(r_len)) begin
            s3_m = r_len - 1'b1;
        end else begin
            s3_m = s3_rnd[LW-1:0];
        end
    end

    logic [OPW:0]  s5_tx, s5_ty;
    logic [EW-1:0] s5_ox, s5_oy, s5_ex, s5_ey;

    always_comb begin
        s5_tx = {1'b0, r4_ox} + (OPW+1)'(1 << (FRAC_BITS - 1));
        s5_ty = {1'b0, r4_oy} + (OPW+1)'(1 << (FRAC_BITS - 1));
        s5_ox = EW'(s5_tx[OPW:FRAC_BITS]);
        s5_oy = EW'(s5_ty[OPW:FRAC_BITS]);
        if (r_cneg) begin
            s5_ox = ~s5_ox + 1'b1;
        end
        if (r_sneg) begin
            s5_oy = ~s5_oy + 1'b1;
        end
        s5_ex = {{(EW-CW){r_sx[CW-1]}}, r_sx} + s5_ox - {{(EW-CW){r4_px[CW-1]}}, r4_px};
        s5_ey = {{(EW-CW){r_sy[CW-1]}}, r_sy} + s5_oy - {{(EW-CW){r4_py[CW-1]}}, r4_py};
        if (s5_ex[EW-1]) begin
            s5_ex = ~s5_ex + 1'b1;
        end
        if (s5_ey[EW-1]) begin
            s5_ey = ~s5_ey + 1'b1;
        end
    end

    logic [2*NR-1:0] r_srad  [0:NR];
    logic [RW-1:0]   r_srem  [0:NR];
    logic [NR-1:0]   r_sroot [0:NR];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px <= px;
            r1_py <= py;
            r1_mx <= s1_dx[DW-1] ? (~s1_dx + 1'b1) : s1_dx;
            r1_my <= s1_dy[DW-1] ? (~s1_dy + 1'b1) : s1_dy;
            r1_nx <= s1_dx[DW-1];
            r1_ny <= s1_dy[DW-1];

            r2_px <= r1_px;
            r2_py <= r1_py;
            r2_p1 <= PW'(r1_mx) * PW'(r_cmag);
            r2_p2 <= PW'(r1_my) * PW'(r_smag);
            r2_n1 <= r1_nx != r_cneg;
            r2_n2 <= r1_ny != r_sneg;

            r3_px <= r2_px;
            r3_py <= r2_py;
            r3_m  <= s3_m;

            r4_px <= r3_px;
            r4_py <= r3_py;
            r4_ox <= OPW'(r3_m) * OPW'(r_cmag);
            r4_oy <= OPW'(r3_m) * OPW'(r_smag);

            r5_ex <= s5_ex;
            r5_ey <= s5_ey;

            r6_xhh <= (2*HI)'(r5_ex[EW-1:LO]) * (2*HI)'(r5_ex[EW-1:LO]);
            r6_xhl <= EW'(r5_ex[EW-1:LO]) * EW'(r5_ex[LO-1:0]);
            r6_xll <= (2*LO)'(r5_ex[LO-1:0]) * (2*LO)'(r5_ex[LO-1:0]);
            r6_yhh <= (2*HI)'(r5_ey[EW-1:LO]) * (2*HI)'(r5_ey[EW-1:LO]);
            r6_yhl <= EW'(r5_ey[EW-1:LO]) * EW'(r5_ey[LO-1:0]);
            r6_yll <= (2*LO)'(r5_ey[LO-1:0]) * (2*LO)'(r5_ey[LO-1:0]);

            r_srad[0] <= ((2*NR)'(r6_xhh) << (2*LO)) + ((2*NR)'(r6_xhl) << (LO+1))
                       + (2*NR)'(r6_xll)
                       + ((2*NR)'(r6_yhh) << (2*LO)) + ((2*NR)'(r6_yhl) << (LO+1))
                       + (2*NR)'(r6_yll);
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < NR; k++) begin : g_sqrt
        logic [RW-1:0] c_sh, c_t;
        assign c_sh = {r_srem[k][RW-3:0], r_srad[k][2*NR-1 -: 2]};
        assign c_t  = RW'({r_sroot[k], 2'b01});
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srad[k+1] <= r_srad[k] << 2;
                if (c_sh >= c_t) begin
                    r_srem[k+1]  <= c_sh - c_t;
                    r_sroot[k+1] <= {r_sroot[k][NR-2:0], 1'b1};
                end else begin
                    r_srem[k+1]  <= c_sh;
                    r_sroot[k+1] <= {r_sroot[k][NR-2:0], 1'b0};
                end
            end
        end
    end

    logic [MXW-1:0]    fin_rnd;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_deg;

    assign fin_rnd = (r_srem[NR] > RW'(r_sroot[NR])) ? MXW'(r_sroot[NR]) + 1'b1
                                                      : MXW'(r_sroot[NR]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_dist <= (fin_rnd > MXW'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
                                                              : fin_rnd[DIST_W-1:0];
            r_out_deg  <= r_len == '0;
        end
    end

    assign o_m_tdata = OUT_TW'(r_out_dist);
    assign o_m_tuser = r_out_deg;

    // ---------------- checks ----------------
    a_ready_cached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> r_cache_valid)
        else $error("input taken without a valid direction cache");

    a_write_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !r_cache_valid)
        else $error("register write did not flush the cache");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cache_valid |-> (r_cmag <= FW'(1 << FRAC_BITS)) && (r_smag <= FW'(1 << FRAC_BITS)))
        else $error("direction component above one");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cache_valid && r_len == '0) |-> (r_cmag == '0 && r_smag == '0))
        else $error("zero length segment with nonzero direction");

endmodule
